### src/json_top_level_entry_splitter_assert.svh
// ----------------------------------------------------------------------------
// JSON entry splitter assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_TOP_LEVEL_ENTRY_SPLITTER_ASSERT_SVH
`define JSON_TOP_LEVEL_ENTRY_SPLITTER_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define JTLES_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("jtles: invariant violated");

// Whenever the antecedent holds, the consequent holds at the next edge.
`define JTLES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jtles: next-cycle check failed");

`endif

### src/jtles_pkg.sv
// ----------------------------------------------------------------------------
// JSON entry splitter package
// Character classes, roles, error codes and limits of the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jtles_pkg;

    localparam int MAX_DEPTH   = 255;
    localparam int MAX_ENTRIES = 4095;

    localparam int DEPTH_W = 8;
    localparam int ENTRY_W = 12;

    localparam int DEPTH_LIMIT_INT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
    localparam int ENTRY_LIMIT_INT = (MAX_ENTRIES < 4095) ? MAX_ENTRIES : 4095;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(DEPTH_LIMIT_INT);
    localparam logic [ENTRY_W-1:0] ENTRY_LIMIT = ENTRY_W'(ENTRY_LIMIT_INT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] CC_OTHER  = 4'd0;
    localparam logic [3:0] CC_WS     = 4'd1;
    localparam logic [3:0] CC_LBRACE = 4'd2;
    localparam logic [3:0] CC_RBRACE = 4'd3;
    localparam logic [3:0] CC_LBRACK = 4'd4;
    localparam logic [3:0] CC_RBRACK = 4'd5;
    localparam logic [3:0] CC_COLON  = 4'd6;
    localparam logic [3:0] CC_COMMA  = 4'd7;
    localparam logic [3:0] CC_QUOTE  = 4'd8;
    localparam logic [3:0] CC_BSLASH = 4'd9;

    localparam logic [2:0] ROLE_IGNORED   = 3'd0;
    localparam logic [2:0] ROLE_OPEN      = 3'd1;
    localparam logic [2:0] ROLE_KEY_QUOTE = 3'd2;
    localparam logic [2:0] ROLE_KEY_BYTE  = 3'd3;
    localparam logic [2:0] ROLE_COLON     = 3'd4;
    localparam logic [2:0] ROLE_VALUE     = 3'd5;
    localparam logic [2:0] ROLE_COMMA     = 3'd6;
    localparam logic [2:0] ROLE_CLOSE     = 3'd7;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_OBJECT = 4'd1;
    localparam logic [3:0] ERR_KEY       = 4'd2;
    localparam logic [3:0] ERR_COLON     = 4'd3;
    localparam logic [3:0] ERR_VALUE     = 4'd4;
    localparam logic [3:0] ERR_SEPARATOR = 4'd5;
    localparam logic [3:0] ERR_STRING    = 4'd6;
    localparam logic [3:0] ERR_BRACKET   = 4'd7;
    localparam logic [3:0] ERR_END       = 4'd8;
    localparam logic [3:0] ERR_DEPTH     = 4'd9;

    typedef struct packed {
        logic [3:0] cls;
        logic       first;
        logic       last;
    } token_t;

endpackage

### src/jtles_front.sv
// ----------------------------------------------------------------------------
// JSON entry splitter front end
// Accepts text words, classifies each character and pushes it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtles_front
    import jtles_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       queue_full,
    output logic       push,
    output token_t     push_token
);

    logic [3:0] cls;

    always_comb
    begin
        case (text_byte)
            8'h7B:   cls = CC_LBRACE;
            8'h7D:   cls = CC_RBRACE;
            8'h5B:   cls = CC_LBRACK;
            8'h5D:   cls = CC_RBRACK;
            8'h3A:   cls = CC_COLON;
            8'h2C:   cls = CC_COMMA;
            8'h22:   cls = CC_QUOTE;
            8'h5C:   cls = CC_BSLASH;
            default:
            begin
                if (text_byte == 8'h20 || text_byte inside {[8'h09:8'h0D]})
                    cls = CC_WS;
                else
                    cls = CC_OTHER;
            end
        endcase
    end

    assign in_stall         = queue_full;
    assign push             = in_valid && !queue_full;
    assign push_token.cls   = cls;
    assign push_token.first = first_byte;
    assign push_token.last  = last_byte;

endmodule

### src/jtles_queue.sv
// ----------------------------------------------------------------------------
// JSON entry splitter token queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtles_queue
    import jtles_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    output logic   full,
    output logic   head_valid,
    output token_t head_token,
    input  logic   pop
);

    token_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_token;
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = slot_reg[rd_ptr_reg];

endmodule

### src/jtles_back.sv
// ----------------------------------------------------------------------------
// JSON entry splitter back end
// Runs the object phase machine on queued tokens and registers each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_top_level_entry_splitter_assert.svh"

module jtles_back
    import jtles_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  token_t             head_token,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         byte_role,
    output logic [ENTRY_W-1:0] entry_index,
    output logic               done_res,
    output logic [3:0]         error_code
);

    localparam logic [3:0] PH_OPEN     = 4'd0;
    localparam logic [3:0] PH_FIRST    = 4'd1;
    localparam logic [3:0] PH_KEYWAIT  = 4'd2;
    localparam logic [3:0] PH_KEY      = 4'd3;
    localparam logic [3:0] PH_COLON    = 4'd4;
    localparam logic [3:0] PH_VALWAIT  = 4'd5;
    localparam logic [3:0] PH_NESTED   = 4'd6;
    localparam logic [3:0] PH_STRVAL   = 4'd7;
    localparam logic [3:0] PH_BARE     = 4'd8;
    localparam logic [3:0] PH_AFTERVAL = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    logic [3:0]         phase_reg;
    logic [3:0]         phase_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               esc_reg;
    logic               esc_next;
    logic               instr_reg;
    logic               instr_next;
    logic               arr_reg;
    logic               arr_next;
    logic [ENTRY_W-1:0] cnt_reg;
    logic [ENTRY_W-1:0] cnt_next;
    logic [3:0]         err_reg;
    logic [3:0]         err_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [2:0]         role_reg;
    logic [2:0]         role_next;
    logic [ENTRY_W-1:0] idx_reg;
    logic               done_reg;
    logic               done_next;
    logic [3:0]         code_reg;

    logic [3:0]         cur_phase;
    logic [DEPTH_W-1:0] cur_depth;
    logic               cur_esc;
    logic               cur_instr;
    logic               cur_arr;
    logic [ENTRY_W-1:0] cur_cnt;
    logic [3:0]         cur_err;
    logic               open_hit;
    logic               close_hit;
    logic [DEPTH_W-1:0] depth_dec;
    logic [3:0]         cls;

    assign pop = head_valid && (!out_valid_reg || !out_stall);
    assign cls = head_token.cls;

    always_comb
    begin
        if (head_token.first)
        begin
            cur_phase = PH_OPEN;
            cur_depth = '0;
            cur_esc   = 1'b0;
            cur_instr = 1'b0;
            cur_arr   = 1'b0;
            cur_cnt   = '0;
            cur_err   = ERR_NONE;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_depth = depth_reg;
            cur_esc   = esc_reg;
            cur_instr = instr_reg;
            cur_arr   = arr_reg;
            cur_cnt   = cnt_reg;
            cur_err   = err_reg;
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        depth_next = cur_depth;
        esc_next   = cur_esc;
        instr_next = cur_instr;
        arr_next   = cur_arr;
        cnt_next   = cur_cnt;
        err_next   = cur_err;
        role_next  = ROLE_IGNORED;
        open_hit   = cur_arr ? (cls == CC_LBRACK) : (cls == CC_LBRACE);
        close_hit  = cur_arr ? (cls == CC_RBRACK) : (cls == CC_RBRACE);
        depth_dec  = (cur_depth != '0) ? cur_depth - 1'b1 : '0;

        if (cur_err == ERR_NONE)
        begin
            case (cur_phase)
                PH_OPEN:
                begin
                    if (cls == CC_LBRACE)
                    begin
                        role_next  = ROLE_OPEN;
                        phase_next = PH_FIRST;
                    end
                    else if (cls != CC_WS)
                        err_next = ERR_NO_OBJECT;
                end
                PH_FIRST, PH_KEYWAIT:
                begin
                    if (cls == CC_QUOTE)
                    begin
                        role_next  = ROLE_KEY_QUOTE;
                        esc_next   = 1'b0;
                        phase_next = PH_KEY;
                    end
                    else if (cls == CC_RBRACE && cur_phase == PH_FIRST)
                    begin
                        role_next  = ROLE_CLOSE;
                        phase_next = PH_DONE;
                    end
                    else if (cls != CC_WS)
                        err_next = ERR_KEY;
                end
                PH_KEY:
                begin
                    role_next = ROLE_KEY_BYTE;
                    if (cur_esc)
                        esc_next = 1'b0;
                    else if (cls == CC_BSLASH)
                        esc_next = 1'b1;
                    else if (cls == CC_QUOTE)
                    begin
                        role_next  = ROLE_KEY_QUOTE;
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (cls == CC_COLON)
                    begin
                        role_next  = ROLE_COLON;
                        phase_next = PH_VALWAIT;
                    end
                    else if (cls != CC_WS)
                        err_next = ERR_COLON;
                end
                PH_VALWAIT:
                begin
                    if (cls inside {CC_LBRACE, CC_LBRACK})
                    begin
                        role_next  = ROLE_VALUE;
                        arr_next   = (cls == CC_LBRACK);
                        instr_next = 1'b0;
                        esc_next   = 1'b0;
                        if (DEPTH_LIMIT == '0)
                            err_next = ERR_DEPTH;
                        else
                        begin
                            depth_next = DEPTH_W'(1);
                            phase_next = PH_NESTED;
                        end
                    end
                    else if (cls == CC_QUOTE)
                    begin
                        role_next  = ROLE_VALUE;
                        esc_next   = 1'b0;
                        phase_next = PH_STRVAL;
                    end
                    else if (cls inside {CC_COMMA, CC_RBRACE, CC_RBRACK})
                        err_next = ERR_VALUE;
                    else if (cls != CC_WS)
                    begin
                        role_next  = ROLE_VALUE;
                        phase_next = PH_BARE;
                    end
                end
                PH_NESTED:
                begin
                    if (cur_instr)
                    begin
                        role_next = ROLE_VALUE;
                        if (cur_esc)
                            esc_next = 1'b0;
                        else if (cls == CC_BSLASH)
                            esc_next = 1'b1;
                        else if (cls == CC_QUOTE)
                            instr_next = 1'b0;
                    end
                    else if (cls == CC_QUOTE)
                    begin
                        role_next  = ROLE_VALUE;
                        instr_next = 1'b1;
                        esc_next   = 1'b0;
                    end
                    else if (open_hit)
                    begin
                        if (cur_depth >= DEPTH_LIMIT)
                            err_next = ERR_DEPTH;
                        else
                        begin
                            role_next  = ROLE_VALUE;
                            depth_next = cur_depth + 1'b1;
                        end
                    end
                    else if (close_hit)
                    begin
                        role_next  = ROLE_VALUE;
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                            phase_next = PH_AFTERVAL;
                    end
                    else
                        role_next = ROLE_VALUE;
                end
                PH_STRVAL:
                begin
                    role_next = ROLE_VALUE;
                    if (cur_esc)
                        esc_next = 1'b0;
                    else if (cls == CC_BSLASH)
                        esc_next = 1'b1;
                    else if (cls == CC_QUOTE)
                        phase_next = PH_AFTERVAL;
                end
                PH_BARE, PH_AFTERVAL:
                begin
                    if (cls == CC_WS)
                        phase_next = PH_AFTERVAL;
                    else if (cls == CC_COMMA)
                    begin
                        role_next  = ROLE_COMMA;
                        phase_next = PH_KEYWAIT;
                        if (cur_cnt < ENTRY_LIMIT)
                            cnt_next = cur_cnt + 1'b1;
                    end
                    else if (cls == CC_RBRACE)
                    begin
                        role_next  = ROLE_CLOSE;
                        phase_next = PH_DONE;
                    end
                    else if (cur_phase == PH_BARE && cls != CC_RBRACK)
                        role_next = ROLE_VALUE;
                    else
                        err_next = ERR_SEPARATOR;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (head_token.last && err_next == ERR_NONE && phase_next != PH_DONE)
            begin
                case (phase_next)
                    PH_OPEN:               err_next = ERR_NO_OBJECT;
                    PH_FIRST, PH_KEYWAIT:  err_next = ERR_KEY;
                    PH_KEY, PH_STRVAL:     err_next = ERR_STRING;
                    PH_COLON:              err_next = ERR_COLON;
                    PH_VALWAIT:            err_next = ERR_END;
                    PH_NESTED:             err_next = instr_next ? ERR_STRING : ERR_BRACKET;
                    default:               err_next = ERR_SEPARATOR;
                endcase
            end
        end

        done_next = (phase_next == PH_DONE) && (err_next == ERR_NONE);
    end

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            depth_reg     <= '0;
            esc_reg       <= 1'b0;
            instr_reg     <= 1'b0;
            arr_reg       <= 1'b0;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                esc_reg   <= esc_next;
                instr_reg <= instr_next;
                arr_reg   <= arr_next;
                cnt_reg   <= cnt_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            role_reg <= role_next;
            idx_reg  <= cur_cnt;
            done_reg <= done_next;
            code_reg <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_role   = role_reg;
    assign entry_index = idx_reg;
    assign done_res    = done_reg;
    assign error_code  = code_reg;

    `JTLES_ASSERT_ALWAYS(a_done_has_no_error, phase_reg != PH_DONE || err_reg == ERR_NONE)
    `JTLES_ASSERT_ALWAYS(a_depth_in_limit, depth_reg <= DEPTH_LIMIT)
    `JTLES_ASSERT_ALWAYS(a_count_in_limit, cnt_reg <= ENTRY_LIMIT)
    `JTLES_ASSERT_NEXT(a_error_sticky, pop && !head_token.first && err_reg != ERR_NONE,
        err_reg == $past(err_reg) && byte_role == ROLE_IGNORED)
    `JTLES_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall,
        out_valid_reg && $stable(role_reg) && $stable(idx_reg) && $stable(code_reg))

endmodule

### src/json_top_level_entry_splitter.sv
// ----------------------------------------------------------------------------
// JSON top-level entry splitter
// Tags the role of every byte of a text in a shallow top-level JSON object.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  text_byte, first_byte, last_byte
// out      output     out_valid/out_stall byte_role, entry_index, done_res, error_code
//
// One word is accepted per cycle while in_stall is low; the phase machine handles
// one token a cycle unless out_stall holds its result. An accepted word waits in the
// queue until popped, and its result is then registered. Reset clears all scan state
// at once; no start-up sweep is needed. A two-word queue sits between the classifier
// and the phase machine. in_stall rises only when that queue holds two words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_top_level_entry_splitter
    import jtles_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         text_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         byte_role,
    output logic [ENTRY_W-1:0] entry_index,
    output logic               done_res,
    output logic [3:0]         error_code
);

    logic   queue_full;
    logic   push;
    token_t push_token;
    logic   head_valid;
    token_t head_token;
    logic   pop;

    jtles_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_token (push_token)
    );

    jtles_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_token (head_token),
        .pop        (pop)
    );

    jtles_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_token  (head_token),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_role   (byte_role),
        .entry_index (entry_index),
        .done_res    (done_res),
        .error_code  (error_code)
    );

endmodule
